>>> sv/bts_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Sizes, codes and helper functions shared by the sampler files.
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int WEIGHT_BITS = 4;

	// full weight scale: sixteenths per axis
	localparam int WGT_W  = 4;
	localparam int BW_W   = 2 * WGT_W + 1;          // corner weight, 0..256
	localparam int BW_ONE = 1 << (2 * WGT_W);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);     // holds 1..MAX_DIM
	localparam int CRD_W  = $clog2(MAX_DIM);         // holds 0..MAX_DIM-1
	localparam int MUL_W  = CRD_W + DIM_W;

	localparam int PIX_W  = 32;
	localparam int IDX_W  = 12;
	localparam int CRD_IN_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int FX_W   = CRD_IN_W + 1;            // coordinate minus one half
	localparam int INT_W  = FX_W - FRAC_BITS;        // floor of the coordinate
	localparam int HALF_PIXEL = (1 << FRAC_BITS) / 2;

	localparam int CH_N   = 4;
	localparam int CH_W   = 8;
	localparam int PRD_W  = CH_W + BW_W;
	localparam int SUM_W  = PRD_W + 2;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int DIM_RESET = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// saturate a dimension register into 1..maxv
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r, input int maxv);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (int'(r) > maxv) begin
			d = DIM_W'(maxv);
		end else begin
			d = DIM_W'(r);
		end
		return d;
	endfunction

	// clamp a signed coordinate into 0..d-1
	function automatic logic [CRD_W-1:0] clamp_crd(input logic [INT_W:0] a,
			input logic [DIM_W-1:0] d);
		logic [CRD_W-1:0] c;
		if (a[INT_W]) begin
			c = '0;
		end else if (a >= (INT_W+1)'(d)) begin
			c = CRD_W'(d - DIM_W'(1));
		end else begin
			c = CRD_W'(a);
		end
		return c;
	endfunction

endpackage

>>> sv/bts_in_if.sv
// ----------------------------------------------------------------------------
// Sampler request channel
// Pixel write or sample request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bts_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  opcode;
	logic [bts_pkg::IDX_W-1:0]             pixel_index;
	logic [bts_pkg::PIX_W-1:0]             pixel_value;
	logic signed [bts_pkg::CRD_IN_W-1:0]   sample_x;
	logic signed [bts_pkg::CRD_IN_W-1:0]   sample_y;

	modport source (output valid, opcode, pixel_index, pixel_value, sample_x, sample_y,
		input ready);
	modport sink (input valid, opcode, pixel_index, pixel_value, sample_x, sample_y,
		output ready);
endinterface

>>> sv/bts_out_if.sv
// ----------------------------------------------------------------------------
// Sampler result channel
// Filtered ARGB32 colour with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bts_out_if;
	logic                      valid;
	logic                      ready;
	logic [bts_pkg::PIX_W-1:0] filtered_color;

	modport source (output valid, filtered_color, input ready);
	modport sink (input valid, filtered_color, output ready);
endinterface

>>> sv/bts_cfg_if.sv
// ----------------------------------------------------------------------------
// Sampler configuration channel
// Register write: index and data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bts_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bts_pkg::CFG_IDX_W-1:0] index;
	logic [bts_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/bilinear_texture_sampler_top.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// Throughput, unless the result is stalled: one request per cycle,
// writes and samples mixed freely; the rate is set by two copies of the
// pixel store, each read at two addresses. Reset clears pipeline valids
// and sets both dimensions to 64; the pixel store is not cleared and
// holds nothing defined until written.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_top (
	input  logic      clk,
	input  logic      arst_n,
	bts_cfg_if.sink   cfg,
	bts_in_if.sink    req,
	bts_out_if.source rsp
);

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken
	// ------------------------------------------------------------------
	logic [bts_pkg::CFG_W-1:0] img_w_q, img_h_q;
	logic [bts_pkg::DIM_W-1:0] eff_w, eff_h;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= bts_pkg::CFG_W'(bts_pkg::DIM_RESET);
			img_h_q <= bts_pkg::CFG_W'(bts_pkg::DIM_RESET);
		end else if (cfg.valid) begin
			unique case (bts_pkg::cfg_reg_t'(cfg.index))
				bts_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg.data;
				bts_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// saturate into the store's geometry
	assign eff_w = bts_pkg::eff_dim(img_w_q, bts_pkg::MAX_WIDTH);
	assign eff_h = bts_pkg::eff_dim(img_h_q, bts_pkg::MAX_HEIGHT);

	// ------------------------------------------------------------------
	// Stage enables: a stage advances when it is empty or its successor
	// advances, so bubbles collapse and a held result never blocks input
	// while room is left upstream.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !v_s6 || rsp.ready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// ------------------------------------------------------------------
	// Stage 1: shift by one half pixel, split into floor and weight
	// ------------------------------------------------------------------
	logic [bts_pkg::FX_W-1:0] fx_c, fy_c;

	assign fx_c = {req.sample_x[bts_pkg::CRD_IN_W-1], req.sample_x}
		- bts_pkg::FX_W'(bts_pkg::HALF_PIXEL);
	assign fy_c = {req.sample_y[bts_pkg::CRD_IN_W-1], req.sample_y}
		- bts_pkg::FX_W'(bts_pkg::HALF_PIXEL);

	bts_pkg::op_t                   op_s1, op_s2, op_s3;
	logic [bts_pkg::IDX_W-1:0]      idx_s1, idx_s2, idx_s3;
	logic [bts_pkg::PIX_W-1:0]      pix_s1, pix_s2, pix_s3;
	logic [bts_pkg::INT_W-1:0]      x0_s1, y0_s1;
	logic [bts_pkg::WGT_W-1:0]      dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1  <= bts_pkg::op_t'(req.opcode);
			idx_s1 <= req.pixel_index;
			pix_s1 <= req.pixel_value;
			// the upper bits of the shifted coordinate are its floor
			x0_s1  <= fx_c[bts_pkg::FX_W-1:bts_pkg::FRAC_BITS];
			y0_s1  <= fy_c[bts_pkg::FX_W-1:bts_pkg::FRAC_BITS];
			dx_s1  <= bts_pkg::WGT_W'(fx_c[bts_pkg::FRAC_BITS-1 -: bts_pkg::WEIGHT_BITS])
				<< (bts_pkg::WGT_W - bts_pkg::WEIGHT_BITS);
			dy_s1  <= bts_pkg::WGT_W'(fy_c[bts_pkg::FRAC_BITS-1 -: bts_pkg::WEIGHT_BITS])
				<< (bts_pkg::WGT_W - bts_pkg::WEIGHT_BITS);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: clamp the four neighbours, form the corner weights
	// ------------------------------------------------------------------
	logic [bts_pkg::INT_W:0]   x0_e, y0_e, x1_e, y1_e;
	logic [bts_pkg::BW_W-1:0]  wxy_c, wdx_c, wdy_c;

	assign x0_e = {x0_s1[bts_pkg::INT_W-1], x0_s1};
	assign y0_e = {y0_s1[bts_pkg::INT_W-1], y0_s1};
	assign x1_e = x0_e + (bts_pkg::INT_W+1)'(1);
	assign y1_e = y0_e + (bts_pkg::INT_W+1)'(1);
	assign wxy_c = bts_pkg::BW_W'(dx_s1) * bts_pkg::BW_W'(dy_s1);
	assign wdx_c = bts_pkg::BW_W'(dx_s1) << bts_pkg::WGT_W;
	assign wdy_c = bts_pkg::BW_W'(dy_s1) << bts_pkg::WGT_W;

	logic [bts_pkg::CRD_W-1:0] cx0_s2, cx1_s2, cy0_s2, cy1_s2;
	// corner weights in order top-left, top-right, bottom-left, bottom-right
	logic [bts_pkg::BW_W-1:0]  wt_s2 [bts_pkg::CH_N];
	logic [bts_pkg::BW_W-1:0]  wt_s3 [bts_pkg::CH_N];
	logic [bts_pkg::BW_W-1:0]  wt_s4 [bts_pkg::CH_N];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			pix_s2 <= pix_s1;
			cx0_s2 <= bts_pkg::clamp_crd(x0_e, eff_w);
			cx1_s2 <= bts_pkg::clamp_crd(x1_e, eff_w);
			cy0_s2 <= bts_pkg::clamp_crd(y0_e, eff_h);
			cy1_s2 <= bts_pkg::clamp_crd(y1_e, eff_h);
			wt_s2[0] <= bts_pkg::BW_W'(bts_pkg::BW_ONE) - wdy_c - wdx_c + wxy_c;
			wt_s2[1] <= wdx_c - wxy_c;
			wt_s2[2] <= wdy_c - wxy_c;
			wt_s2[3] <= wxy_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: row-major store addresses of the four neighbours
	// ------------------------------------------------------------------
	logic [bts_pkg::MUL_W-1:0]  row0_c, row1_c;
	logic [bts_pkg::ADDR_W-1:0] a_tl_s3, a_tr_s3, a_bl_s3, a_br_s3;

	assign row0_c = bts_pkg::MUL_W'(cy0_s2) * bts_pkg::MUL_W'(eff_w);
	assign row1_c = bts_pkg::MUL_W'(cy1_s2) * bts_pkg::MUL_W'(eff_w);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3   <= op_s2;
			idx_s3  <= idx_s2;
			pix_s3  <= pix_s2;
			a_tl_s3 <= bts_pkg::ADDR_W'(row0_c + bts_pkg::MUL_W'(cx0_s2));
			a_tr_s3 <= bts_pkg::ADDR_W'(row0_c + bts_pkg::MUL_W'(cx1_s2));
			a_bl_s3 <= bts_pkg::ADDR_W'(row1_c + bts_pkg::MUL_W'(cx0_s2));
			a_br_s3 <= bts_pkg::ADDR_W'(row1_c + bts_pkg::MUL_W'(cx1_s2));
			wt_s3   <= wt_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: pixel store. Two copies take every write; copy A serves
	// the top row, copy B the bottom row. Writes happen in the same stage
	// as reads, so a sample behind a write always sees it.
	// ------------------------------------------------------------------
	logic [bts_pkg::PIX_W-1:0] mem_a [bts_pkg::DEPTH];
	logic [bts_pkg::PIX_W-1:0] mem_b [bts_pkg::DEPTH];
	logic [bts_pkg::PIX_W-1:0] tl_s4, tr_s4, bl_s4, br_s4;
	logic                      wr_en;

	// drop writes beyond the store
	assign wr_en = v_s3 && en_s4 && (op_s3 == bts_pkg::OP_WRITE)
		&& (int'(idx_s3) < bts_pkg::DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[bts_pkg::ADDR_W'(idx_s3)] <= pix_s3;
			mem_b[bts_pkg::ADDR_W'(idx_s3)] <= pix_s3;
		end
		if (en_s4) begin
			tl_s4 <= mem_a[a_tl_s3];
			tr_s4 <= mem_a[a_tr_s3];
			bl_s4 <= mem_b[a_bl_s3];
			br_s4 <= mem_b[a_br_s3];
			wt_s4 <= wt_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: weight every channel of every corner
	// ------------------------------------------------------------------
	logic [bts_pkg::PIX_W-1:0] corner_c [bts_pkg::CH_N];
	logic [bts_pkg::PRD_W-1:0] prd_c    [bts_pkg::CH_N][bts_pkg::CH_N];
	logic [bts_pkg::PRD_W-1:0] prd_s5   [bts_pkg::CH_N][bts_pkg::CH_N];

	assign corner_c[0] = tl_s4;
	assign corner_c[1] = tr_s4;
	assign corner_c[2] = bl_s4;
	assign corner_c[3] = br_s4;

	always_comb begin
		for (int k = 0; k < bts_pkg::CH_N; k++) begin
			for (int c = 0; c < bts_pkg::CH_N; c++) begin
				prd_c[k][c] = bts_pkg::PRD_W'(corner_c[k][c*bts_pkg::CH_W +: bts_pkg::CH_W])
					* bts_pkg::PRD_W'(wt_s4[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			prd_s5 <= prd_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: sum the corners and truncate by 8 bits; result register
	// ------------------------------------------------------------------
	logic [bts_pkg::SUM_W-1:0] sum_c [bts_pkg::CH_N];
	logic [bts_pkg::PIX_W-1:0] col_c, col_s6;

	always_comb begin
		for (int c = 0; c < bts_pkg::CH_N; c++) begin
			sum_c[c] = bts_pkg::SUM_W'(prd_s5[0][c]) + bts_pkg::SUM_W'(prd_s5[1][c])
				+ bts_pkg::SUM_W'(prd_s5[2][c]) + bts_pkg::SUM_W'(prd_s5[3][c]);
			col_c[c*bts_pkg::CH_W +: bts_pkg::CH_W] = sum_c[c][2*bts_pkg::CH_W-1:bts_pkg::CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			col_s6 <= col_c;
		end
	end

	assign rsp.valid          = v_s6;
	assign rsp.filtered_color = col_s6;

	// ------------------------------------------------------------------
	// Valid bits; a write retires once it passes the store stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3 && (op_s3 == bts_pkg::OP_SAMPLE);
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

endmodule

>>> sv/bts_checker.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler port checker
// Watches the top level's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module bts_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [bts_pkg::PIX_W-1:0] rsp_color
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color))
		else $error("result dropped or changed while stalled");

	// an empty or draining result register never blocks new requests
	a_req_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_ready || !rsp_valid) |-> req_ready)
		else $error("request blocked while the result side can advance");

	// no result can appear in the cycle after reset
	a_rst_quiet: assert property (@(posedge clk)
		$past(!arst_n) |-> !rsp_valid)
		else $error("result shown straight after reset");

	// the request side is ready straight after reset is released
	a_rst_ready: assert property (@(posedge clk)
		$past(!arst_n) && arst_n |-> req_ready)
		else $error("request side not ready after reset");

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_color (rsp.filtered_color)
);

>>> tb/sv/bilinear_texture_sampler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Loads pixels and samples them under several image sizes, with random gaps
// on requests and random back-pressure on results. A behavioural filter in
// the bench predicts every colour, which is compared against the block's output.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_top_tb;

	localparam int WEIGHT_ONE = 1 << bts_pkg::WGT_W;   // one pixel in weight units

	typedef struct {
		bts_pkg::op_t                          opcode;
		logic [bts_pkg::IDX_W-1:0]             pixel_index;
		logic [bts_pkg::PIX_W-1:0]             pixel_value;
		logic signed [bts_pkg::CRD_IN_W-1:0]   sample_x;
		logic signed [bts_pkg::CRD_IN_W-1:0]   sample_y;
	} sampler_req_t;

	// store addresses of the four neighbours: top-left, top-right,
	// bottom-left, bottom-right
	typedef logic [3:0][bts_pkg::ADDR_W-1:0] tap_set_t;

	logic clk;
	logic arst_n;

	bts_cfg_if cfg_ch ();
	bts_in_if  req_ch ();
	bts_out_if rsp_ch ();

	bilinear_texture_sampler_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Shared state
	// ------------------------------------------------------------------
	sampler_req_t              request_queue [$];    // items waiting for the driver
	logic [bts_pkg::PIX_W-1:0] expected_colors [$];  // predicted colours, oldest first

	// predictor's copy of the block
	logic [bts_pkg::PIX_W-1:0] texel_mem [bts_pkg::DEPTH];
	logic [bts_pkg::CFG_W-1:0] width_reg;
	logic [bts_pkg::CFG_W-1:0] height_reg;

	// generator's view: which store entries hold a defined pixel, and the
	// image size in force for the phase being generated
	bit               texel_written [bts_pkg::DEPTH];
	int               gen_w;
	int               gen_h;

	int unsigned      items_queued;
	int unsigned      items_accepted;
	int unsigned      results_seen;
	int unsigned      mismatch_count;

	int unsigned      req_gap;
	bit               req_calm;
	int unsigned      rsp_stall;
	int unsigned      rsp_hold;
	bit               rsp_calm;

	// ------------------------------------------------------------------
	// Filter arithmetic
	// ------------------------------------------------------------------

	// Saturate a dimension register into 1..maxv.
	function automatic int saturate_dim(input logic [bts_pkg::CFG_W-1:0] r, input int maxv);
		if (r == '0) begin
			return 1;
		end
		return (int'(r) > maxv) ? maxv : int'(r);
	endfunction

	function automatic int clamp_axis(input longint a, input int d);
		if (a < 0) begin
			return 0;
		end
		return (a > d - 1) ? d - 1 : int'(a);
	endfunction

	// Shift by half a pixel with a wide intermediate so the extremes never
	// wrap; the floor of the result is the top-left neighbour.
	function automatic tap_set_t tap_addrs(input logic signed [bts_pkg::CRD_IN_W-1:0] sx,
			input logic signed [bts_pkg::CRD_IN_W-1:0] sy, input int w, input int h);
		longint   x0, y0;
		int       cx0, cx1, cy0, cy1;
		tap_set_t taps;
		x0  = (longint'(sx) - bts_pkg::HALF_PIXEL) >>> bts_pkg::FRAC_BITS;
		y0  = (longint'(sy) - bts_pkg::HALF_PIXEL) >>> bts_pkg::FRAC_BITS;
		cx0 = clamp_axis(x0, w);
		cx1 = clamp_axis(x0 + 1, w);
		cy0 = clamp_axis(y0, h);
		cy1 = clamp_axis(y0 + 1, h);
		taps[0] = bts_pkg::ADDR_W'(cy0 * w + cx0);
		taps[1] = bts_pkg::ADDR_W'(cy0 * w + cx1);
		taps[2] = bts_pkg::ADDR_W'(cy1 * w + cx0);
		taps[3] = bts_pkg::ADDR_W'(cy1 * w + cx1);
		return taps;
	endfunction

	// Top fractional bits of the shifted coordinate, in sixteenths.
	function automatic int frac_weight(input logic signed [bts_pkg::CRD_IN_W-1:0] c);
		longint f;
		f = longint'(c) - bts_pkg::HALF_PIXEL;
		return int'((f >> (bts_pkg::FRAC_BITS - bts_pkg::WEIGHT_BITS))
			& ((1 << bts_pkg::WEIGHT_BITS) - 1)) << (bts_pkg::WGT_W - bts_pkg::WEIGHT_BITS);
	endfunction

	// Bilinear colour at a sample position, from the predictor's store and
	// registers. Each channel is blended separately and truncated by 8 bits.
	function automatic logic [bts_pkg::PIX_W-1:0] filter_sample(
			input logic signed [bts_pkg::CRD_IN_W-1:0] sx,
			input logic signed [bts_pkg::CRD_IN_W-1:0] sy);
		int                        wx, wy, acc;
		int                        wgt [4];
		tap_set_t                  taps;
		logic [bts_pkg::PIX_W-1:0] color;
		taps = tap_addrs(sx, sy, saturate_dim(width_reg, bts_pkg::MAX_WIDTH),
			saturate_dim(height_reg, bts_pkg::MAX_HEIGHT));
		wx = frac_weight(sx);
		wy = frac_weight(sy);
		wgt[0] = (WEIGHT_ONE - wx) * (WEIGHT_ONE - wy);
		wgt[1] = wx * (WEIGHT_ONE - wy);
		wgt[2] = (WEIGHT_ONE - wx) * wy;
		wgt[3] = wx * wy;
		for (int c = 0; c < bts_pkg::CH_N; c++) begin
			acc = 0;
			for (int t = 0; t < 4; t++) begin
				acc += int'(texel_mem[taps[t]][c*bts_pkg::CH_W +: bts_pkg::CH_W]) * wgt[t];
			end
			color[c*bts_pkg::CH_W +: bts_pkg::CH_W] =
				bts_pkg::CH_W'(acc >> (2 * bts_pkg::WGT_W));
		end
		return color;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	// Queue a pixel load; the unused coordinate fields carry noise.
	task automatic queue_write(input logic [bts_pkg::IDX_W-1:0] idx,
			input logic [bts_pkg::PIX_W-1:0] val);
		sampler_req_t item;
		item.opcode      = bts_pkg::OP_WRITE;
		item.pixel_index = idx;
		item.pixel_value = val;
		item.sample_x    = $urandom;
		item.sample_y    = $urandom;
		request_queue.push_back(item);
		texel_written[idx] = 1'b1;
		items_queued++;
	endtask

	// Queue a sample, loading first any neighbour that has never been
	// written so that no undefined store entry is ever read.
	task automatic queue_sample(input logic signed [bts_pkg::CRD_IN_W-1:0] sx,
			input logic signed [bts_pkg::CRD_IN_W-1:0] sy);
		sampler_req_t item;
		tap_set_t     taps;
		taps = tap_addrs(sx, sy, gen_w, gen_h);
		for (int t = 0; t < 4; t++) begin
			if (!texel_written[taps[t]]) begin
				queue_write(bts_pkg::IDX_W'(taps[t]), $urandom);
			end
		end
		item.opcode      = bts_pkg::OP_SAMPLE;
		item.pixel_index = $urandom;
		item.pixel_value = $urandom;
		item.sample_x    = sx;
		item.sample_y    = sy;
		request_queue.push_back(item);
		items_queued++;
	endtask

	function automatic logic signed [bts_pkg::CRD_IN_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0000_8000;
		endcase
	endfunction

	// Write one register over the configuration channel.
	task automatic write_reg(input bts_pkg::cfg_reg_t idx,
			input logic [bts_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// ------------------------------------------------------------------
	// Request driver: pop the next item, hold it until the transfer, then
	// idle for a drawn number of cycles. Calm stretches draw no gaps, and
	// while the receiver holds off the sender keeps offering back to back
	// so the pipeline fills and back-pressures the input.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : request_driver
		sampler_req_t item;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_gap      <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_gap != 0) begin
				req_ch.valid <= 1'b0;
				req_gap      <= req_gap - 1;
			end else if (request_queue.size() != 0) begin
				item = request_queue.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.opcode      <= item.opcode;
				req_ch.pixel_index <= item.pixel_index;
				req_ch.pixel_value <= item.pixel_value;
				req_ch.sample_x    <= item.sample_x;
				req_ch.sample_y    <= item.sample_y;
				if ($urandom_range(0, 49) == 0) begin
					req_calm = !req_calm;
				end
				req_gap <= (req_calm || rsp_hold != 0) ? 0 : $urandom_range(0, 16);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Predictor: track register writes and every request transfer, and
	// queue the colour each sample must produce.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sampler_predictor
		if (!arst_n) begin
			width_reg  = bts_pkg::CFG_W'(bts_pkg::DIM_RESET);
			height_reg = bts_pkg::CFG_W'(bts_pkg::DIM_RESET);
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (bts_pkg::cfg_reg_t'(cfg_ch.index))
					bts_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_ch.data;
					bts_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_ch.data;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				items_accepted++;
				if (bts_pkg::op_t'(req_ch.opcode) == bts_pkg::OP_WRITE) begin
					texel_mem[req_ch.pixel_index] = req_ch.pixel_value;
				end else begin
					expected_colors.push_back(filter_sample(req_ch.sample_x, req_ch.sample_y));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check each colour transfer against the oldest
	// prediction, then draw a stall before the next one. Twice in the run
	// the receiver holds off for a long stretch.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		int unsigned stall;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall    <= 0;
			rsp_hold     <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (expected_colors.size() == 0) begin
					$error("filtered_color: expected none, actual %08h", rsp_ch.filtered_color);
					mismatch_count++;
				end else if (expected_colors[0] !== rsp_ch.filtered_color) begin
					$error("filtered_color: expected %08h, actual %08h",
						expected_colors[0], rsp_ch.filtered_color);
					mismatch_count++;
					void'(expected_colors.pop_front());
				end else begin
					void'(expected_colors.pop_front());
				end
			end

			if (rsp_hold != 0) begin
				rsp_hold     <= rsp_hold - 1;
				rsp_ch.ready <= (rsp_hold == 1);
			end else if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_seen == 40 || results_seen == 400) begin
					rsp_hold     <= 400;
					rsp_ch.ready <= 1'b0;
				end else begin
					if ($urandom_range(0, 49) == 0) begin
						rsp_calm = !rsp_calm;
					end
					stall = rsp_calm ? 0 : $urandom_range(0, 16);
					rsp_stall    <= stall;
					rsp_ch.ready <= (stall == 0);
				end
			end else if (rsp_stall != 0) begin
				rsp_stall    <= rsp_stall - 1;
				rsp_ch.ready <= (rsp_stall == 1);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, a directed set plus a random mix at the reset size,
	// then random phases, each behind a register change made with the block idle.
	// ------------------------------------------------------------------
	initial begin
		logic [bts_pkg::CFG_W-1:0]           wv, hv;
		logic signed [bts_pkg::CRD_IN_W-1:0] sx, sy;
		int unsigned                         pick;
		int unsigned                         guard;

		// hold the configuration inputs at a known value from time zero
		arst_n             = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		gen_w              = saturate_dim(bts_pkg::CFG_W'(bts_pkg::DIM_RESET),
			bts_pkg::MAX_WIDTH);
		gen_h              = saturate_dim(bts_pkg::CFG_W'(bts_pkg::DIM_RESET),
			bts_pkg::MAX_HEIGHT);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 0) begin
				// directed set at the reset size of 64 x 64
				@(negedge clk);
				queue_write(12'd0, 32'h0000_0000);
				queue_write(12'd4095, 32'hffff_ffff);
				queue_write(12'd2081, 32'ha5c3_3c5a);
				// top-left corner: half a pixel up and left clamps to pixel 0
				queue_sample(32'h0000_0000, 32'h0000_0000);
				// coordinates at the 32-bit limits: no wrap, clamp to the edges
				queue_sample(32'h7fff_ffff, 32'h7fff_ffff);
				queue_sample(32'h8000_0000, 32'h8000_0000);
				queue_sample(32'h8000_0000, 32'h7fff_ffff);
				queue_sample(32'hffff_ffff, 32'h0000_8000);
				// pixel centre: both weights zero, one pixel passes through
				queue_sample(32'h0005_8000, 32'h0007_8000);
				// largest fractional weight on both axes
				queue_sample(32'h0006_7000, 32'h0006_7000);
				queue_sample(32'h0014_1234, 32'h001e_c000);
				// right and bottom edges: neighbours clamp to width-1, height-1
				queue_sample(32'h0040_0000, 32'h0040_0000);
				queue_sample(32'h0040_0000, 32'h0000_0000);
				// overwrite a pixel already sampled and read it again
				queue_write(12'd0, 32'h8040_20ff);
				queue_sample(32'h0000_0000, 32'h0000_0000);
			end else begin
				// drain: every expected colour back, then let trailing writes
				// clear the pipeline before touching the registers
				do begin
					@(negedge clk);
				end while (items_accepted != items_queued || expected_colors.size() != 0);
				repeat (10) @(negedge clk);

				case (ph)
					1: begin wv = 7'd0;   hv = 7'd0;   end   // saturate up to 1 x 1
					2: begin wv = 7'd127; hv = 7'd127; end   // saturate down to 64 x 64
					3: begin wv = 7'd1;   hv = 7'd64;  end
					4: begin wv = 7'd64;  hv = 7'd1;   end
					5: begin wv = 7'd2;   hv = 7'd3;   end
					default: begin
						wv = bts_pkg::CFG_W'($urandom_range(0, 127));
						hv = bts_pkg::CFG_W'($urandom_range(0, 127));
					end
				endcase
				write_reg(bts_pkg::REG_IMAGE_WIDTH, wv);
				write_reg(bts_pkg::REG_IMAGE_HEIGHT, hv);
				gen_w = saturate_dim(wv, bts_pkg::MAX_WIDTH);
				gen_h = saturate_dim(hv, bts_pkg::MAX_HEIGHT);
				@(negedge clk);
			end

			// random mix: writes anywhere or inside the image, samples mostly
			// around the image, some anywhere, some at the limits
			repeat (85) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					if ($urandom_range(0, 1) == 1) begin
						queue_write(bts_pkg::IDX_W'($urandom_range(0, bts_pkg::DEPTH - 1)),
							$urandom);
					end else begin
						queue_write(bts_pkg::IDX_W'($urandom_range(0, gen_w * gen_h - 1)),
							$urandom);
					end
				end else if (pick < 85) begin
					sx = (int'($urandom_range(0, gen_w + 3)) - 2) * 65536
						+ int'($urandom_range(0, 65535));
					sy = (int'($urandom_range(0, gen_h + 3)) - 2) * 65536
						+ int'($urandom_range(0, 65535));
					queue_sample(sx, sy);
				end else if (pick < 95) begin
					queue_sample($urandom, $urandom);
				end else begin
					queue_sample(pick_extreme(), pick_extreme());
				end
			end
		end

		// wait for the last transfers and colours, bounded, then let the
		// pipeline settle so that any stray result is caught
		guard = 0;
		while ((items_accepted != items_queued || expected_colors.size() != 0)
				&& guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);

		if (expected_colors.size() != 0) begin
			$error("filtered_color: %0d expected results never arrived",
				expected_colors.size());
			mismatch_count++;
		end

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Watchdog: far beyond the slowest legal run
	// ------------------------------------------------------------------
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
sv/bts_pkg.sv
sv/bts_in_if.sv
sv/bts_out_if.sv
sv/bts_cfg_if.sv
sv/bilinear_texture_sampler_top.sv
sv/bts_checker.sv
tb/sv/bilinear_texture_sampler_top_tb.sv
